### rtl/core/stt_pkg.sv
// Package for the source text tokenizer: token kinds, scan modes, error codes,
// result record type and character-class helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stt_pkg;

  localparam int unsigned PositionBitsDef = 20;
  localparam int unsigned KindBits = 6;
  localparam int unsigned ErrBits = 2;
  localparam int unsigned MaxTokens = 3;

  // Token kinds.
  localparam logic [5:0] KLparen = 6'd0;
  localparam logic [5:0] KRparen = 6'd1;
  localparam logic [5:0] KLbrace = 6'd2;
  localparam logic [5:0] KRbrace = 6'd3;
  localparam logic [5:0] KSemi = 6'd4;
  localparam logic [5:0] KComma = 6'd5;
  localparam logic [5:0] KDot = 6'd6;
  localparam logic [5:0] KMinus = 6'd7;
  localparam logic [5:0] KPlus = 6'd8;
  localparam logic [5:0] KSlash = 6'd9;
  localparam logic [5:0] KStar = 6'd10;
  localparam logic [5:0] KBang = 6'd11;
  localparam logic [5:0] KAssign = 6'd13;
  localparam logic [5:0] KLess = 6'd15;
  localparam logic [5:0] KGreater = 6'd17;
  localparam logic [5:0] KString = 6'd19;
  localparam logic [5:0] KNumber = 6'd20;
  localparam logic [5:0] KIdent = 6'd21;
  localparam logic [5:0] KTrue = 6'd22;
  localparam logic [5:0] KFalse = 6'd23;
  localparam logic [5:0] KDeclBrace = 6'd24;
  localparam logic [5:0] KDeclBracket = 6'd25;
  localparam logic [5:0] KDeclLess = 6'd26;
  localparam logic [5:0] KDeclPipe = 6'd27;
  localparam logic [5:0] KDeclPercent = 6'd28;
  localparam logic [5:0] KDeclEqual = 6'd29;
  localparam logic [5:0] KEol = 6'd30;
  localparam logic [5:0] KError = 6'd31;
  localparam logic [5:0] KEof = 6'd32;

  // Error codes.
  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrUnexpected = 2'd1;
  localparam logic [1:0] ErrUntermString = 2'd2;

  // Keyword matcher progress for "@true" and "@false".
  localparam logic [3:0] KwNone = 4'd0;
  localparam logic [3:0] KwAt = 4'd1;
  localparam logic [3:0] KwT = 4'd2;
  localparam logic [3:0] KwTr = 4'd3;
  localparam logic [3:0] KwTru = 4'd4;
  localparam logic [3:0] KwTrue = 4'd5;
  localparam logic [3:0] KwF = 4'd6;
  localparam logic [3:0] KwFa = 4'd7;
  localparam logic [3:0] KwFal = 4'd8;
  localparam logic [3:0] KwFals = 4'd9;
  localparam logic [3:0] KwFalse = 4'd10;

  // Scan modes, one-hot.
  typedef enum logic [11:0] {
    ModeIdle     = 12'b0000_0000_0001,
    ModeOp2      = 12'b0000_0000_0010,
    ModeSlash    = 12'b0000_0000_0100,
    ModeComment  = 12'b0000_0000_1000,
    ModeNumInt   = 12'b0000_0001_0000,
    ModeNumDot   = 12'b0000_0010_0000,
    ModeNumFrac  = 12'b0000_0100_0000,
    ModeIdent    = 12'b0000_1000_0000,
    ModeString   = 12'b0001_0000_0000,
    ModeDeclPre  = 12'b0010_0000_0000,
    ModeDeclName = 12'b0100_0000_0000,
    ModeDeclPost = 12'b1000_0000_0000
  } scan_mode_e;

  // One token as produced by the scan step, positions at full 32-bit width
  // and narrowed by the user.
  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] noff;
    logic [31:0] nlen;
    logic [1:0]  err;
  } token_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return (b == 8'h20) || (b == 8'h0d) || (b == 8'h09);
  endfunction

  function automatic logic [3:0] next_match(logic [3:0] m, logic [7:0] b);
    logic [3:0] r;
    r = KwNone;
    case (m)
      KwAt:   r = (b == "t") ? KwT : ((b == "f") ? KwF : KwNone);
      KwT:    r = (b == "r") ? KwTr : KwNone;
      KwTr:   r = (b == "u") ? KwTru : KwNone;
      KwTru:  r = (b == "e") ? KwTrue : KwNone;
      KwF:    r = (b == "a") ? KwFa : KwNone;
      KwFa:   r = (b == "l") ? KwFal : KwNone;
      KwFal:  r = (b == "s") ? KwFals : KwNone;
      KwFals: r = (b == "e") ? KwFalse : KwNone;
      default: r = KwNone;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/stt_scan.sv
// Scan step of the source text tokenizer: from the scanner state and one
// registered item, computes the next state and up to three tokens.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stt_scan #(
  parameter int unsigned PositionBits = stt_pkg::PositionBitsDef
) (
  input  wire logic [7:0]              byte_i,
  input  wire logic                    eot_i,
  input  wire stt_pkg::scan_mode_e     mode_i,
  input  wire logic [PositionBits-1:0] pos_i,
  input  wire logic [PositionBits-1:0] tstart_i,
  input  wire logic [PositionBits-1:0] line_i,
  input  wire logic [5:0]              pend_i,
  input  wire logic [PositionBits-1:0] nstart_i,
  input  wire logic [PositionBits-1:0] nlen_i,
  input  wire logic [3:0]              kw_i,
  output stt_pkg::scan_mode_e          mode_o,
  output logic [PositionBits-1:0]      pos_o,
  output logic [PositionBits-1:0]      tstart_o,
  output logic [PositionBits-1:0]      line_o,
  output logic [5:0]                   pend_o,
  output logic [PositionBits-1:0]      nstart_o,
  output logic [PositionBits-1:0]      nlen_o,
  output logic [3:0]                   kw_o,
  output stt_pkg::token_t [2:0]        tok_o,
  output logic [2:0]                   tok_line_sel_o,
  output logic [1:0]                   count_o
);

  localparam logic [PositionBits-1:0] PosLimit = '1;

  function automatic logic [PositionBits-1:0] sat_inc(logic [PositionBits-1:0] v);
    return (v == PosLimit) ? v : v + 1'b1;
  endfunction

  function automatic logic [31:0] wid(logic [PositionBits-1:0] v);
    return 32'(v);
  endfunction

  logic [PositionBits-1:0] p, pinc, dotp;

  // Token slots are filled in order; tok_line_sel is held at zero, so no slot
  // is marked as seeing the incremented line.
  always_comb begin
    logic [1:0] n;
    logic       restart;
    logic [5:0] skind;
    logic       eolcase;
    n = 2'd0;
    restart = 1'b0;
    eolcase = 1'b0;
    skind = stt_pkg::KError;
    p = pos_i;
    pinc = sat_inc(pos_i);
    dotp = (pos_i > tstart_i) ? pos_i - 1'b1 : tstart_i;
    mode_o = mode_i;
    pos_o = pinc;
    tstart_o = tstart_i;
    line_o = line_i;
    pend_o = pend_i;
    nstart_o = nstart_i;
    nlen_o = nlen_i;
    kw_o = kw_i;
    tok_o = '0;
    tok_line_sel_o = '0;

    if (eot_i) begin
      // End of text: flush what is pending, then eof, then reset the state.
      unique case (mode_i)
        stt_pkg::ModeOp2: begin
          tok_o[n] = '{pend_i, wid(tstart_i), wid(p - tstart_i), 0, 0, stt_pkg::ErrNone};
          n = n + 1'b1;
        end
        stt_pkg::ModeSlash: begin
          tok_o[n] = '{stt_pkg::KSlash, wid(tstart_i), wid(p - tstart_i), 0, 0,
                       stt_pkg::ErrNone};
          n = n + 1'b1;
        end
        stt_pkg::ModeNumInt, stt_pkg::ModeNumFrac: begin
          tok_o[n] = '{stt_pkg::KNumber, wid(tstart_i), wid(p - tstart_i), 0, 0,
                       stt_pkg::ErrNone};
          n = n + 1'b1;
        end
        stt_pkg::ModeNumDot: begin
          tok_o[0] = '{stt_pkg::KNumber, wid(tstart_i), wid(dotp - tstart_i), 0, 0,
                       stt_pkg::ErrNone};
          tok_o[1] = '{stt_pkg::KDot, wid(dotp), 32'd1, 0, 0, stt_pkg::ErrNone};
          n = 2'd2;
        end
        stt_pkg::ModeIdent: begin
          tok_o[n] = '{(kw_i == stt_pkg::KwTrue) ? stt_pkg::KTrue :
                       (kw_i == stt_pkg::KwFalse) ? stt_pkg::KFalse : stt_pkg::KIdent,
                       wid(tstart_i), wid(p - tstart_i), 0, 0, stt_pkg::ErrNone};
          n = n + 1'b1;
        end
        stt_pkg::ModeString: begin
          tok_o[n] = '{stt_pkg::KError, wid(tstart_i), wid(p - tstart_i), 0, 0,
                       stt_pkg::ErrUntermString};
          n = n + 1'b1;
        end
        stt_pkg::ModeDeclPre, stt_pkg::ModeDeclName, stt_pkg::ModeDeclPost: begin
          tok_o[n] = '{stt_pkg::KError, wid(tstart_i), wid(p - tstart_i), 0, 0,
                       stt_pkg::ErrUnexpected};
          n = n + 1'b1;
        end
        default: ;
      endcase
      tok_o[n] = '{stt_pkg::KEof, wid(p), 32'd0, 0, 0, stt_pkg::ErrNone};
      n = n + 1'b1;
      mode_o = stt_pkg::ModeIdle;
      pos_o = '0;
      tstart_o = '0;
      line_o = PositionBits'(1);
      pend_o = '0;
      nstart_o = '0;
      nlen_o = '0;
      kw_o = stt_pkg::KwNone;
    end else begin
      // Continue the token in progress; a byte that ends it is rescanned.
      unique case (mode_i)
        stt_pkg::ModeOp2: begin
          if (byte_i == "=") begin
            tok_o[n] = '{pend_i + 6'd1, wid(tstart_i), wid(pinc - tstart_i), 0, 0,
                         stt_pkg::ErrNone};
            n = n + 1'b1;
            mode_o = stt_pkg::ModeIdle;
          end else begin
            tok_o[n] = '{pend_i, wid(tstart_i), wid(p - tstart_i), 0, 0, stt_pkg::ErrNone};
            n = n + 1'b1;
            restart = 1'b1;
          end
        end
        stt_pkg::ModeSlash: begin
          if (byte_i == "/") begin
            mode_o = stt_pkg::ModeComment;
          end else begin
            tok_o[n] = '{stt_pkg::KSlash, wid(tstart_i), wid(p - tstart_i), 0, 0,
                         stt_pkg::ErrNone};
            n = n + 1'b1;
            restart = 1'b1;
          end
        end
        stt_pkg::ModeComment: restart = (byte_i == 8'h0a);
        stt_pkg::ModeNumInt: begin
          if (byte_i == ".") begin
            mode_o = stt_pkg::ModeNumDot;
          end else if (!stt_pkg::is_digit(byte_i)) begin
            tok_o[n] = '{stt_pkg::KNumber, wid(tstart_i), wid(p - tstart_i), 0, 0,
                         stt_pkg::ErrNone};
            n = n + 1'b1;
            restart = 1'b1;
          end
        end
        stt_pkg::ModeNumDot: begin
          if (stt_pkg::is_digit(byte_i)) begin
            mode_o = stt_pkg::ModeNumFrac;
          end else begin
            tok_o[0] = '{stt_pkg::KNumber, wid(tstart_i), wid(dotp - tstart_i), 0, 0,
                         stt_pkg::ErrNone};
            tok_o[1] = '{stt_pkg::KDot, wid(dotp), 32'd1, 0, 0, stt_pkg::ErrNone};
            n = 2'd2;
            restart = 1'b1;
          end
        end
        stt_pkg::ModeNumFrac: begin
          if (!stt_pkg::is_digit(byte_i)) begin
            tok_o[n] = '{stt_pkg::KNumber, wid(tstart_i), wid(p - tstart_i), 0, 0,
                         stt_pkg::ErrNone};
            n = n + 1'b1;
            restart = 1'b1;
          end
        end
        stt_pkg::ModeIdent: begin
          if (stt_pkg::is_alpha(byte_i) || stt_pkg::is_digit(byte_i)) begin
            kw_o = stt_pkg::next_match(kw_i, byte_i);
          end else begin
            tok_o[n] = '{(kw_i == stt_pkg::KwTrue) ? stt_pkg::KTrue :
                         (kw_i == stt_pkg::KwFalse) ? stt_pkg::KFalse : stt_pkg::KIdent,
                         wid(tstart_i), wid(p - tstart_i), 0, 0, stt_pkg::ErrNone};
            n = n + 1'b1;
            restart = 1'b1;
          end
        end
        stt_pkg::ModeString: begin
          if (byte_i == 8'h22) begin
            tok_o[n] = '{stt_pkg::KString, wid(tstart_i), wid(pinc - tstart_i), 0, 0,
                         stt_pkg::ErrNone};
            n = n + 1'b1;
            mode_o = stt_pkg::ModeIdle;
          end else if (byte_i == 8'h0a) begin
            line_o = sat_inc(line_i);
          end
        end
        stt_pkg::ModeDeclPre, stt_pkg::ModeDeclName, stt_pkg::ModeDeclPost: begin
          if (stt_pkg::is_blank(byte_i)) begin
            if (mode_i == stt_pkg::ModeDeclName) mode_o = stt_pkg::ModeDeclPost;
          end else if ((stt_pkg::is_alpha(byte_i) || stt_pkg::is_digit(byte_i)) &&
                       (mode_i != stt_pkg::ModeDeclPost)) begin
            if (mode_i == stt_pkg::ModeDeclPre) begin
              nstart_o = p;
              nlen_o = PositionBits'(1);
              mode_o = stt_pkg::ModeDeclName;
            end else begin
              nlen_o = sat_inc(nlen_i);
            end
          end else begin
            // Selector byte closes the declaration.
            if (mode_i == stt_pkg::ModeDeclPre) begin
              nstart_o = p;
              nlen_o = '0;
            end
            case (byte_i)
              "{": skind = stt_pkg::KDeclBrace;
              "[": skind = stt_pkg::KDeclBracket;
              "<": skind = stt_pkg::KDeclLess;
              "|": skind = stt_pkg::KDeclPipe;
              "%": skind = stt_pkg::KDeclPercent;
              "=": skind = stt_pkg::KDeclEqual;
              default: skind = stt_pkg::KError;
            endcase
            mode_o = stt_pkg::ModeIdle;
            if (skind == stt_pkg::KError) begin
              tok_o[n] = '{stt_pkg::KError, wid(tstart_i), wid(pinc - tstart_i), 0, 0,
                           stt_pkg::ErrUnexpected};
            end else begin
              tok_o[n] = '{skind, wid(tstart_i), wid(pinc - tstart_i), wid(nstart_o),
                           wid(nlen_o), stt_pkg::ErrNone};
            end
            n = n + 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase

      // Start of a new token at this byte.
      if (restart) begin
        mode_o = stt_pkg::ModeIdle;
        if (!stt_pkg::is_blank(byte_i)) begin
          tstart_o = p;
          if (stt_pkg::is_digit(byte_i)) begin
            mode_o = stt_pkg::ModeNumInt;
          end else if (stt_pkg::is_alpha(byte_i) || byte_i == "@") begin
            mode_o = stt_pkg::ModeIdent;
            kw_o = (byte_i == "@") ? stt_pkg::KwAt : stt_pkg::KwNone;
          end else begin
            skind = stt_pkg::KError;
            case (byte_i)
              "(": skind = stt_pkg::KLparen;
              ")": skind = stt_pkg::KRparen;
              "{": skind = stt_pkg::KLbrace;
              "}": skind = stt_pkg::KRbrace;
              ";": skind = stt_pkg::KSemi;
              ",": skind = stt_pkg::KComma;
              ".": skind = stt_pkg::KDot;
              "-": skind = stt_pkg::KMinus;
              "+": skind = stt_pkg::KPlus;
              "*": skind = stt_pkg::KStar;
              "/": mode_o = stt_pkg::ModeSlash;
              "!": begin pend_o = stt_pkg::KBang; mode_o = stt_pkg::ModeOp2; end
              "=": begin pend_o = stt_pkg::KAssign; mode_o = stt_pkg::ModeOp2; end
              "<": begin pend_o = stt_pkg::KLess; mode_o = stt_pkg::ModeOp2; end
              ">": begin pend_o = stt_pkg::KGreater; mode_o = stt_pkg::ModeOp2; end
              8'h22: mode_o = stt_pkg::ModeString;
              "#": begin
                nstart_o = '0;
                nlen_o = '0;
                mode_o = stt_pkg::ModeDeclPre;
              end
              8'h0a: begin
                skind = stt_pkg::KEol;
                eolcase = 1'b1;
              end
              default: skind = stt_pkg::KError;
            endcase
            if ((mode_o == stt_pkg::ModeIdle)) begin
              tok_o[n] = '{skind, wid(p), 32'd1, 0, 0,
                           (skind == stt_pkg::KError) ? stt_pkg::ErrUnexpected
                                                      : stt_pkg::ErrNone};
              n = n + 1'b1;
              if (eolcase) line_o = sat_inc(line_i);
            end
          end
        end
      end
    end
    count_o = n;
  end

endmodule
`default_nettype wire

### rtl/core/source_text_tokenizer_core.sv
// Top level of the source text tokenizer: input register, scan step, token
// queue and output register. Depends on stt_pkg and stt_scan.
`timescale 1ns / 1ps
`default_nettype none
// The tokenizer takes one source byte per item and sustains one item per cycle
// while each item yields at most one token and the output is not stalled. An
// accepted item is held in an input register and scanned from there; its tokens
// (up to three) enter a small queue and leave one per cycle, while the output is
// not stalled, through the output register, so an item that yields two or three
// tokens can hold the input back. Every token of an item carries the line counter
// as it stood before that item was scanned.
module source_text_tokenizer_core #(
  parameter int unsigned PositionBits = stt_pkg::PositionBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tuser,   // [0] end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [5:0] token_kind, [25:6] start_offset, [45:26] token_length,
  // [65:46] name_offset, [85:66] name_length, [105:86] line_number,
  // [107:106] error_code, [111:108] zero
  output logic [111:0]     m_axis_tdata,
  output logic             m_axis_tlast    // last_of_run
);

  localparam int unsigned QDepth = 4;

  typedef struct packed {
    logic [5:0]  kind;
    logic [19:0] start;
    logic [19:0] len;
    logic [19:0] noff;
    logic [19:0] nlen;
    logic [19:0] line;
    logic [1:0]  err;
    logic        last;
  } out_t;

  // Input register.
  logic       in_v_q;
  logic [7:0] in_b_q;
  logic       in_e_q;

  // Scanner state.
  stt_pkg::scan_mode_e mode_q, mode_d;
  logic [PositionBits-1:0] pos_q, pos_d, ts_q, ts_d, line_q, line_d;
  logic [PositionBits-1:0] ns_q, ns_d, nl_q, nl_d;
  logic [5:0] pend_q, pend_d;
  logic [3:0] kw_q, kw_d;
  stt_pkg::token_t [2:0] tok;
  logic [2:0] lsel;
  logic [1:0] cnt;

  stt_scan #(.PositionBits(PositionBits)) u_scan (
    .byte_i(in_b_q), .eot_i(in_e_q), .mode_i(mode_q), .pos_i(pos_q), .tstart_i(ts_q),
    .line_i(line_q), .pend_i(pend_q), .nstart_i(ns_q), .nlen_i(nl_q), .kw_i(kw_q),
    .mode_o(mode_d), .pos_o(pos_d), .tstart_o(ts_d), .line_o(line_d), .pend_o(pend_d),
    .nstart_o(ns_d), .nlen_o(nl_d), .kw_o(kw_d), .tok_o(tok), .tok_line_sel_o(lsel),
    .count_o(cnt)
  );

  // Token queue of out_t entries.
  out_t       q_mem [QDepth];
  logic [1:0] wr_q, rd_q;
  logic [2:0] fill_q;
  logic       fire, pop, push_ok;

  // Space must exist for three tokens before the scanned item is retired.
  assign fire = in_v_q && (fill_q <= 3'(QDepth - 3) || (fill_q == 3'(QDepth - 2) && pop));
  assign push_ok = fire;
  assign s_axis_tready = !in_v_q || fire;

  assign pop = (fill_q != 3'd0) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      mode_q <= stt_pkg::ModeIdle;
      pos_q  <= '0;
      ts_q   <= '0;
      line_q <= PositionBits'(1);
      pend_q <= '0;
      ns_q   <= '0;
      nl_q   <= '0;
      kw_q   <= stt_pkg::KwNone;
    end else begin
      if (s_axis_tready) in_v_q <= s_axis_tvalid;
      if (fire) begin
        mode_q <= mode_d;
        pos_q  <= pos_d;
        ts_q   <= ts_d;
        line_q <= line_d;
        pend_q <= pend_d;
        ns_q   <= ns_d;
        nl_q   <= nl_d;
        kw_q   <= kw_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_b_q <= s_axis_tdata;
      in_e_q <= s_axis_tuser;
    end
  end

  // Queue write: tokens of the item in order, every slot with the same line.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < cnt) begin
          q_mem[2'(wr_q + 2'(i))] <= '{
            tok[i].kind, tok[i].start[19:0], tok[i].len[19:0], tok[i].noff[19:0],
            tok[i].nlen[19:0], 20'(line_q), tok[i].err, (2'(i + 1) == cnt)};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_ok) wr_q <= wr_q + cnt;
      if (pop) rd_q <= rd_q + 2'd1;
      fill_q <= fill_q + (push_ok ? {1'b0, cnt} : 3'd0) - {2'b0, pop};
    end
  end

  // Output register.
  out_t o_q;
  logic o_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_v_q <= 1'b0;
    else if (!o_v_q || m_axis_tready) o_v_q <= pop;
  end
  always_ff @(posedge clk_i) begin
    if (pop) o_q <= q_mem[rd_q];
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata = {4'd0, o_q.err, o_q.line, o_q.nlen, o_q.noff, o_q.len,
                         o_q.start, o_q.kind};
  assign m_axis_tlast = o_q.last;

  logic unused_lsel;
  assign unused_lsel = ^lsel;

endmodule
`default_nettype wire

### rtl/core/stt_checker.sv
// Port-level checker for the source text tokenizer, bound to the top level.
// Depends on stt_pkg for the token kind codes.
`timescale 1ns / 1ps
`default_nettype none
module stt_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [111:0] m_axis_tdata,
  input wire logic         m_axis_tlast
);

  // A held result must not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Token kinds stay within the defined range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[5:0] <= stt_pkg::KEof)
    else $error("token kind out of range");

  // Eof always closes a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5:0] == stt_pkg::KEof |-> m_axis_tlast)
    else $error("eof without last");

  // Line numbers never read zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[105:86] != 20'd0)
    else $error("line number zero");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
